### design/rrs_pkg.sv
package rrs_pkg;

    // Field widths of one input item and one result item.
    localparam int SEQ_IN_W    = 48;
    localparam int HEALTH_W    = 2;
    localparam int INFLIGHT_W  = 16;
    localparam int NODE_W      = 6;
    localparam int MAX_LAG_W   = 48;

    // Packed stream widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 8;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_NODES = 64;
    localparam int DEF_SEQ_BITS  = 48;

    // Health codes.
    localparam logic [HEALTH_W-1:0] HEALTH_HEALTHY   = 2'd0;
    localparam logic [HEALTH_W-1:0] HEALTH_SUSPECT   = 2'd1;
    localparam logic [HEALTH_W-1:0] HEALTH_UNHEALTHY = 2'd2;
    localparam logic [HEALTH_W-1:0] HEALTH_DRAINING  = 2'd3;

    // One replica status as it moves from the input register to the selector.
    typedef struct packed {
        logic [SEQ_IN_W-1:0]   replica_seq;
        logic [HEALTH_W-1:0]   health;
        logic [INFLIGHT_W-1:0] inflight;
        logic [NODE_W-1:0]     node_id;
        logic                  last;
    } t_item;

    // Result of a query, handed to the output register.
    typedef struct packed {
        logic              found;
        logic [NODE_W-1:0] selected_node;
    } t_result;

endpackage

### design/rrs_in_stage.sv
module rrs_in_stage
    import rrs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [IN_TDATA_W-1:0] i_data,
    input  logic                  i_last,
    input  logic                  i_advance,
    output logic                  o_valid,
    output t_item                 o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  w_take;

    // The register takes a new item when it is empty or its item moves on.
    assign o_ready = !r_valid || i_advance;
    assign w_take  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Unpack the stream word, first field in the lowest bits.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.replica_seq <= i_data[SEQ_IN_W-1:0];
            r_item.health      <= i_data[SEQ_IN_W +: HEALTH_W];
            r_item.inflight    <= i_data[SEQ_IN_W+HEALTH_W +: INFLIGHT_W];
            r_item.node_id     <= i_data[SEQ_IN_W+HEALTH_W+INFLIGHT_W +: NODE_W];
            r_item.last        <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### design/rrs_keep_best.sv
module rrs_keep_best
    import rrs_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int SEQ_BITS  = DEF_SEQ_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  t_item                i_item,
    input  logic [MAX_LAG_W-1:0] i_max_lag,
    output t_result              o_result
);

    localparam int CMP_W = (SEQ_BITS > MAX_LAG_W) ? SEQ_BITS : MAX_LAG_W;

    logic                  r_in_query;
    logic [SEQ_BITS-1:0]   r_ref;
    logic                  r_best_valid;
    logic [HEALTH_W-1:0]   r_best_health;
    logic [SEQ_BITS-1:0]   r_best_lag;
    logic [INFLIGHT_W-1:0] r_best_inflight;
    logic [NODE_W-1:0]     r_best_node;

    logic [SEQ_BITS-1:0]   w_seq;
    logic [SEQ_BITS-1:0]   w_ref;
    logic [SEQ_BITS-1:0]   w_lag;
    logic                  w_eligible;
    logic                  w_beats;
    logic                  w_take;

    // The primary of a query supplies its own reference, so its lag is zero.
    assign w_seq = SEQ_BITS'(i_item.replica_seq);
    assign w_ref = r_in_query ? r_ref : w_seq;
    assign w_lag = (w_ref > w_seq) ? (w_ref - w_seq) : '0;

    // Only healthy or suspect replicas inside the group and within the lag limit.
    assign w_eligible = ((i_item.health == HEALTH_HEALTHY) ||
                         (i_item.health == HEALTH_SUSPECT)) &&
                        (CMP_W'(w_lag) <= CMP_W'(i_max_lag)) &&
                        ({1'b0, i_item.node_id} < (NODE_W+1)'(MAX_NODES));

    // Lexicographic order: health, lag, in flight, node; a full tie keeps the old one.
    always_comb begin
        if (!r_best_valid) begin
            w_beats = 1'b1;
        end else if (i_item.health != r_best_health) begin
            w_beats = i_item.health < r_best_health;
        end else if (w_lag != r_best_lag) begin
            w_beats = w_lag < r_best_lag;
        end else if (i_item.inflight != r_best_inflight) begin
            w_beats = i_item.inflight < r_best_inflight;
        end else begin
            w_beats = i_item.node_id < r_best_node;
        end
    end

    assign w_take = w_eligible && w_beats;

    // Query state; the last item closes the query and clears the kept replica.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_query   <= 1'b0;
            r_best_valid <= 1'b0;
        end else if (i_advance) begin
            if (i_item.last) begin
                r_in_query   <= 1'b0;
                r_best_valid <= 1'b0;
            end else begin
                r_in_query   <= 1'b1;
                r_best_valid <= r_best_valid || w_take;
            end
        end
    end

    // Kept replica keys and the reference sequence.
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_ref <= w_ref;
            if (w_take) begin
                r_best_health   <= i_item.health;
                r_best_lag      <= w_lag;
                r_best_inflight <= i_item.inflight;
                r_best_node     <= i_item.node_id;
            end
        end
    end

    // Result as it stands after this item; used only on the last item.
    always_comb begin
        o_result.found         = r_best_valid || w_take;
        o_result.selected_node = '0;
        if (w_take) begin
            o_result.selected_node = i_item.node_id;
        end else if (r_best_valid) begin
            o_result.selected_node = r_best_node;
        end
    end

endmodule

### design/rrs_out_reg.sv
module rrs_out_reg
    import rrs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  t_result                i_result,
    output logic                   o_free,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [OUT_TDATA_W-1:0] o_data,
    output logic                   o_user
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // The slot is free when empty or when its result leaves this cycle.
    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = OUT_TDATA_W'(r_result.selected_node);
    assign o_user  = r_result.found;

endmodule

### design/read_replica_selector.sv
// Read replica selector. Each input item is one replica status; tlast marks the
// final replica of a query, and the first item of a query is the primary whose
// applied sequence sets the reference for lag. Replicas that are unhealthy,
// draining, outside the group or lagging by more than max_lag are skipped; the
// rest are ranked by health, lag, requests in flight and node number. One result
// leaves per query, after its last item: tuser is found and tdata the chosen node
// (0 when none). An item is accepted every cycle; each passes an input register,
// one compare-and-keep step against the best replica so far, and, for the last
// item, an output register, from which the result is presented. Input is stalled
// only while a result waits in the output register and the next last item needs
// that slot. Write max_lag only between queries.
module read_replica_selector
    import rrs_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int SEQ_BITS  = DEF_SEQ_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // replica_seq[47:0], health[49:48], inflight[65:50], node_id[71:66]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                   i_s_axis_tlast,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // selected_node[5:0], zero padding[7:6]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // found[0]
    output logic                   o_m_axis_tuser,
    input  logic                   i_cfg_wr_en,
    input  logic [MAX_LAG_W-1:0]   i_cfg_wr_data
);

    logic [MAX_LAG_W-1:0] r_max_lag;
    logic                 w_item_valid;
    t_item                w_item;
    logic                 w_out_free;
    logic                 w_advance;
    t_result              w_result;

    // Lag limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_lag <= '0;
        end else if (i_cfg_wr_en) begin
            r_max_lag <= i_cfg_wr_data;
        end
    end

    // A registered item moves on unless it is a last item with no free result slot.
    assign w_advance = w_item_valid && (!w_item.last || w_out_free);

    rrs_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_data    (i_s_axis_tdata),
        .i_last    (i_s_axis_tlast),
        .i_advance (w_advance),
        .o_valid   (w_item_valid),
        .o_item    (w_item)
    );

    rrs_keep_best #(
        .MAX_NODES (MAX_NODES),
        .SEQ_BITS  (SEQ_BITS)
    ) u_keep_best (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (w_item),
        .i_max_lag (r_max_lag),
        .o_result  (w_result)
    );

    rrs_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance && w_item.last),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_data   (o_m_axis_tdata),
        .o_user   (o_m_axis_tuser)
    );

endmodule

### test/tb.sv
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rrs_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 300;
    localparam logic [MAX_LAG_W-1:0] LAG_ALL_ONES = {MAX_LAG_W{1'b1}};

    // Clock, reset and block inputs, all known from time zero.
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   i_s_axis_tlast = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tuser;
    logic                   i_cfg_wr_en = 1'b0;
    logic [MAX_LAG_W-1:0]   i_cfg_wr_data = '0;

    // Idle rates in percent, changed per phase.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;
    int unsigned items_sent = 0;

    // Shadow of the selector state and of the max_lag register.
    logic [MAX_LAG_W-1:0]  lag_limit = '0;
    bit                    query_open = 1'b0;
    logic [SEQ_IN_W-1:0]   reference_seq = '0;
    bit                    have_best = 1'b0;
    logic [HEALTH_W-1:0]   best_health = '0;
    logic [SEQ_IN_W-1:0]   best_lag = '0;
    logic [INFLIGHT_W-1:0] best_inflight = '0;
    logic [NODE_W-1:0]     best_node = '0;

    t_result pending_choices[$];
    t_result oldest_choice;

    read_replica_selector uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    // Free-running clock.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Run guard.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("read_replica_selector: mismatch");
            $finish;
        end
    end

    // Receiver side: stall at the rate of the current phase.
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each accepted result with the oldest predicted choice.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_choices.size() == 0) begin
                $error("unexpected result: found %0d, selected_node %0d",
                       o_m_axis_tuser, o_m_axis_tdata[NODE_W-1:0]);
                fail_count++;
            end else begin
                oldest_choice = pending_choices.pop_front();
                if (o_m_axis_tuser !== oldest_choice.found) begin
                    $error("found: expected %0d, actual %0d",
                           oldest_choice.found, o_m_axis_tuser);
                    fail_count++;
                end
                if (o_m_axis_tdata[NODE_W-1:0] !== oldest_choice.selected_node) begin
                    $error("selected_node: expected %0d, actual %0d",
                           oldest_choice.selected_node, o_m_axis_tdata[NODE_W-1:0]);
                    fail_count++;
                end
            end
        end
    end

    // Preference order among eligible replicas.
    function automatic bit outranks_best(logic [HEALTH_W-1:0] health,
                                         logic [SEQ_IN_W-1:0] lag,
                                         logic [INFLIGHT_W-1:0] inflight,
                                         logic [NODE_W-1:0] node);
        if (!have_best) return 1'b1;
        if (health != best_health) return health < best_health;
        if (lag != best_lag) return lag < best_lag;
        if (inflight != best_inflight) return inflight < best_inflight;
        return node < best_node;
    endfunction

    // Fold one accepted replica status into the running choice.
    task automatic rank_replica(input t_item status);
        logic [SEQ_IN_W-1:0] lag;
        t_result choice;
        if (!query_open) begin
            reference_seq = status.replica_seq;
            have_best = 1'b0;
            query_open = 1'b1;
        end
        lag = (reference_seq > status.replica_seq) ?
              reference_seq - status.replica_seq : '0;
        if (status.health < HEALTH_UNHEALTHY && lag <= lag_limit &&
            int'(status.node_id) < DEF_MAX_NODES &&
            outranks_best(status.health, lag, status.inflight, status.node_id)) begin
            have_best = 1'b1;
            best_health = status.health;
            best_lag = lag;
            best_inflight = status.inflight;
            best_node = status.node_id;
        end
        if (status.last) begin
            choice.found = have_best;
            choice.selected_node = have_best ? best_node : '0;
            pending_choices.insert(pending_choices.size(), choice);
            query_open = 1'b0;
            have_best = 1'b0;
        end
    endtask

    function automatic t_item make_status(logic [SEQ_IN_W-1:0] seq,
                                          logic [HEALTH_W-1:0] health,
                                          logic [INFLIGHT_W-1:0] inflight,
                                          logic [NODE_W-1:0] node,
                                          logic last);
        t_item status;
        status.replica_seq = seq;
        status.health = health;
        status.inflight = inflight;
        status.node_id = node;
        status.last = last;
        return status;
    endfunction

    function automatic logic [SEQ_IN_W-1:0] rand_seq();
        logic [63:0] bits;
        bits = {$urandom(), $urandom()};
        return bits[SEQ_IN_W-1:0];
    endfunction

    // Send one item, with a random gap first; returns at the accepting edge.
    task automatic send_status(input t_item status);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {status.node_id, status.inflight, status.health,
                           status.replica_seq};
        i_s_axis_tlast <= status.last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        rank_replica(status);
        items_sent++;
    endtask

    // Stop sending and let every predicted result come out.
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (pending_choices.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write max_lag while the block is idle.
    task automatic set_max_lag(input logic [MAX_LAG_W-1:0] value);
        drain_results();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        lag_limit = value;
    endtask

    // After reset max_lag is 0; an unhealthy primary still sets the reference.
    task automatic test_reset_limit();
        send_status(make_status(48'd100, HEALTH_UNHEALTHY, 16'd0, 6'd5, 1'b0));
        send_status(make_status(48'd99, HEALTH_HEALTHY, 16'd0, 6'd3, 1'b0));
        send_status(make_status(48'd100, HEALTH_SUSPECT, 16'd9, 6'd7, 1'b1));
    endtask

    // A query of one item is judged alone with lag 0.
    task automatic test_single_item();
        send_status(make_status(LAG_ALL_ONES, HEALTH_HEALTHY, 16'hFFFF, 6'd63, 1'b1));
        send_status(make_status(48'd5, HEALTH_DRAINING, 16'd1, 6'd2, 1'b1));
        send_status(make_status(48'd0, HEALTH_HEALTHY, 16'd0, 6'd0, 1'b1));
    endtask

    // Health, then lag, then inflight, then node; a full tie keeps the first.
    task automatic test_preference_order();
        set_max_lag(48'd10);
        send_status(make_status(48'd1000, HEALTH_SUSPECT, 16'd0, 6'd1, 1'b0));
        send_status(make_status(48'd995, HEALTH_HEALTHY, 16'd100, 6'd9, 1'b0));
        send_status(make_status(48'd995, HEALTH_HEALTHY, 16'd50, 6'd20, 1'b0));
        send_status(make_status(48'd995, HEALTH_HEALTHY, 16'd50, 6'd12, 1'b0));
        send_status(make_status(48'd995, HEALTH_HEALTHY, 16'd50, 6'd12, 1'b0));
        send_status(make_status(48'd1003, HEALTH_HEALTHY, 16'hFFFF, 6'd40, 1'b0));
        send_status(make_status(48'd989, HEALTH_HEALTHY, 16'd0, 6'd0, 1'b1));
    endtask

    // A lag equal to max_lag is allowed, one more is not.
    task automatic test_lag_boundary();
        send_status(make_status(LAG_ALL_ONES, HEALTH_UNHEALTHY, 16'd0, 6'd8, 1'b0));
        send_status(make_status(LAG_ALL_ONES - 48'd10, HEALTH_HEALTHY, 16'd7, 6'd2, 1'b0));
        send_status(make_status(LAG_ALL_ONES - 48'd11, HEALTH_HEALTHY, 16'd0, 6'd1, 1'b1));
    endtask

    // Largest max_lag and the widest possible lag.
    task automatic test_field_extremes();
        set_max_lag(LAG_ALL_ONES);
        send_status(make_status(LAG_ALL_ONES, HEALTH_HEALTHY, 16'hFFFF, 6'd63, 1'b0));
        send_status(make_status(48'd0, HEALTH_HEALTHY, 16'd0, 6'd0, 1'b0));
        send_status(make_status(48'h5555_5555_5555, HEALTH_DRAINING, 16'h5555, 6'h15, 1'b1));
    endtask

    // One well-formed query with random content, aimed at ties and the lag limit.
    task automatic random_query();
        int unsigned count;
        int unsigned pick;
        logic [SEQ_IN_W-1:0] base;
        logic [SEQ_IN_W-1:0] distance;
        logic [INFLIGHT_W-1:0] inflight;
        logic [NODE_W-1:0] node;
        count = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
        pick = $urandom_range(3);
        base = (pick == 0) ? SEQ_IN_W'($urandom_range(100)) :
               (pick == 1) ? LAG_ALL_ONES - SEQ_IN_W'($urandom_range(100)) : rand_seq();
        for (int unsigned k = 0; k < count; k++) begin
            case ($urandom_range(5))
                0: distance = '0;
                1: distance = SEQ_IN_W'($urandom_range(8));
                2: distance = lag_limit + SEQ_IN_W'($urandom_range(2)) - 48'd1;
                3: distance = rand_seq();
                4: distance = SEQ_IN_W'($urandom_range(2000));
                default: distance = '0 - SEQ_IN_W'($urandom_range(50, 1));
            endcase
            inflight = $urandom_range(1) ? INFLIGHT_W'($urandom_range(3)) :
                       INFLIGHT_W'($urandom());
            node = $urandom_range(1) ? NODE_W'($urandom_range(3)) : NODE_W'($urandom());
            send_status(make_status((k == 0) ? base : base - distance,
                                    HEALTH_W'($urandom_range(3)), inflight, node,
                                    k == count - 1));
        end
    endtask

    // Random queries under one idle pattern, with max_lag changed halfway.
    task automatic test_random_queries(input int unsigned idle_pct,
                                       input int unsigned stall_pct,
                                       input logic [MAX_LAG_W-1:0] first_limit,
                                       input logic [MAX_LAG_W-1:0] second_limit);
        int unsigned start;
        set_max_lag(first_limit);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS / 2) random_query();
        set_max_lag(second_limit);
        while (items_sent - start < PHASE_ITEMS) random_query();
    endtask

    // Test sequence.
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_limit();
        test_single_item();
        test_preference_order();
        test_lag_boundary();
        test_field_extremes();
        test_random_queries(0, 0, '0, MAX_LAG_W'($urandom_range(16)));
        test_random_queries(77, 0, LAG_ALL_ONES, rand_seq());
        test_random_queries(0, 77, 48'd1, MAX_LAG_W'($urandom_range(64)));
        test_random_queries(36, 36, MAX_LAG_W'($urandom_range(1000)), LAG_ALL_ONES);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain_results();
        if (fail_count == 0) begin
            $display("read_replica_selector: match");
        end else begin
            $display("read_replica_selector: mismatch");
        end
        $finish;
    end

endmodule

### files.f
design/rrs_pkg.sv
design/rrs_in_stage.sv
design/rrs_keep_best.sv
design/rrs_out_reg.sv
design/read_replica_selector.sv
test/tb.sv
